// ===== src/lpg_pkg.sv =====
// line pixel generator package
// command and status types shared by the controller, datapath and top level
`default_nettype none

package lpg_pkg;

	typedef struct packed {
		logic load;
		logic step;
	} lpg_cmd_t;

	typedef struct packed {
		logic last;
	} lpg_sts_t;

endpackage

`default_nettype wire

// ===== src/lpg_dpath.sv =====
// line pixel generator datapath: endpoint deltas, decision variable, pixel position
// depends on lpg_pkg for the command and status types
`default_nettype none

module lpg_dpath #(
	parameter int COORD_WIDTH = 6
) (
	input  wire logic                   clk,
	input  wire lpg_pkg::lpg_cmd_t      cmd,
	output lpg_pkg::lpg_sts_t           sts,
	input  wire logic [COORD_WIDTH-1:0] start_x,
	input  wire logic [COORD_WIDTH-1:0] start_y,
	input  wire logic [COORD_WIDTH-1:0] end_x,
	input  wire logic [COORD_WIDTH-1:0] end_y,
	output logic [COORD_WIDTH-1:0]      pixel_x,
	output logic [COORD_WIDTH-1:0]      pixel_y
);
	import lpg_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = COORD_WIDTH + 3;

	logic signed [W:0]  dx;
	logic signed [W:0]  dy;
	logic [W:0]         adx_w;
	logic [W:0]         ady_w;
	logic [W-1:0]       adx;
	logic [W-1:0]       ady;
	logic               x_major;
	logic [W-1:0]       major;
	logic [W-1:0]       minor;
	logic [DW-1:0]      minor2;
	logic [DW-1:0]      major2;
	logic [DW-1:0]      major1;
	logic signed [DW-1:0] d_init;
	logic signed [DW-1:0] inc_pos;
	logic signed [DW-1:0] inc_zero;

	logic [W-1:0]         px_q;
	logic [W-1:0]         py_q;
	logic signed [DW-1:0] d_q;
	logic signed [DW-1:0] inc_pos_q;
	logic signed [DW-1:0] inc_zero_q;
	logic [W-1:0]         cnt_q;
	logic                 x_major_q;
	logic                 x_neg_q;
	logic                 y_neg_q;

	logic         minor_step;
	logic         x_adv;
	logic         y_adv;
	logic [W-1:0] x_delta;
	logic [W-1:0] y_delta;

	// deltas and octant selection at load
	assign dx      = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
	assign dy      = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
	assign adx_w   = dx[W] ? (~dx + 1'b1) : dx;
	assign ady_w   = dy[W] ? (~dy + 1'b1) : dy;
	assign adx     = adx_w[W-1:0];
	assign ady     = ady_w[W-1:0];
	assign x_major = (adx >= ady);
	assign major   = x_major ? adx : ady;
	assign minor   = x_major ? ady : adx;
	assign minor2  = {2'b00, minor, 1'b0};
	assign major2  = {2'b00, major, 1'b0};
	assign major1  = {3'b000, major};
	assign d_init   = $signed(minor2 - major1);
	assign inc_pos  = $signed(minor2 - major2);
	assign inc_zero = $signed(minor2);

	// one bresenham step
	assign minor_step = !d_q[DW-1] && (|d_q);
	assign x_adv      = x_major_q || minor_step;
	assign y_adv      = !x_major_q || minor_step;
	assign x_delta    = x_neg_q ? {W{1'b1}} : {{(W-1){1'b0}}, 1'b1};
	assign y_delta    = y_neg_q ? {W{1'b1}} : {{(W-1){1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q       <= start_x;
			py_q       <= start_y;
			d_q        <= d_init;
			inc_pos_q  <= inc_pos;
			inc_zero_q <= inc_zero;
			cnt_q      <= major;
			x_major_q  <= x_major;
			x_neg_q    <= dx[W];
			y_neg_q    <= dy[W];
		end else if (cmd.step) begin
			d_q   <= d_q + (minor_step ? inc_pos_q : inc_zero_q);
			cnt_q <= cnt_q - 1'b1;
			if (x_adv) begin
				px_q <= px_q + x_delta;
			end
			if (y_adv) begin
				py_q <= py_q + y_delta;
			end
		end
	end

	assign sts.last = (cnt_q == '0);
	assign pixel_x  = px_q;
	assign pixel_y  = py_q;

endmodule

`default_nettype wire

// ===== src/lpg_ctrl.sv =====
// line pixel generator controller: idle/run state machine and handshakes
// depends on lpg_pkg for the command and status types
`default_nettype none

module lpg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output lpg_pkg::lpg_cmd_t      cmd,
	input  wire lpg_pkg::lpg_sts_t sts
);
	import lpg_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic finish;

	// last pixel leaves this cycle
	assign finish    = (state_q == ST_RUN) && sts.last && !out_stall;
	assign in_stall  = (state_q == ST_RUN) && !finish;
	assign out_valid = (state_q == ST_RUN);
	assign cmd.load  = in_valid && !in_stall;
	assign cmd.step  = (state_q == ST_RUN) && !out_stall && !sts.last;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (finish && !cmd.load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_load_and_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step in the same cycle");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ST_IDLE) || (sts.last && !out_stall))
		else $error("new line loaded while pixels remain");

	a_stall_holds_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && out_stall |=> (state_q == ST_RUN))
		else $error("line dropped while output stalled");

	a_step_keeps_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (state_q == ST_RUN))
		else $error("run ended before last pixel");

endmodule

`default_nettype wire

// ===== src/line_pixel_generator.sv =====
// line pixel generator top level: bresenham line drawing over all octants
// joins lpg_ctrl and lpg_dpath, depends on lpg_pkg
//
// input channel: one request carries a line as start_x/start_y and end_x/end_y,
// accepted when in_valid is high and in_stall is low
// output channel: one request per pixel, pixel_x/pixel_y from start to end
// inclusive, last_pixel marks the end point; taken when out_valid and !out_stall
// a line with major delta n gives n+1 pixels, one per cycle while the output
// is not stalled, the first pixel in the cycle after the line is accepted
// the single stepping datapath works on one line at a time, up to 2^COORD_WIDTH
// pixels per line; a new line is taken in the cycle its predecessor's last
// pixel leaves, so lines follow each other without a gap
// while a line is in progress in_stall is high, until its last pixel leaves
// when the receiver stalls, the current pixel holds and stepping pauses
// reset clears the controller to idle with no pixel pending
`default_nettype none

module line_pixel_generator #(
	parameter int COORD_WIDTH = 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [COORD_WIDTH-1:0] start_x,
	input  wire logic [COORD_WIDTH-1:0] start_y,
	input  wire logic [COORD_WIDTH-1:0] end_x,
	input  wire logic [COORD_WIDTH-1:0] end_y,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [COORD_WIDTH-1:0]      pixel_x,
	output logic [COORD_WIDTH-1:0]      pixel_y,
	output logic                        last_pixel
);
	import lpg_pkg::*;

	lpg_cmd_t cmd;
	lpg_sts_t sts;

	lpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lpg_dpath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_dpath (
		.clk     (clk),
		.cmd     (cmd),
		.sts     (sts),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y)
	);

	assign last_pixel = sts.last;

endmodule

`default_nettype wire
